// ===== sv/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared request/response types and codes for the strict-priority queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DROP  = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [3:0]  level;
    logic [15:0] task_id;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_task;
    logic [3:0]  served_level;
    logic        all_empty;
  } rsp_t;

endpackage

// ===== sv/spmq_prio_enc.sv =====
// ----------------------------------------------------------------------------
// spmq_prio_enc
// Picks the lowest-numbered set flag; flag 0 is the highest priority.
// ----------------------------------------------------------------------------
module spmq_prio_enc import spmq_pkg::*; #(
  parameter int unsigned NUM_LEVELS = 16
) (
  input  logic [NUM_LEVELS-1:0]         ne_i,
  output logic [$clog2(NUM_LEVELS)-1:0] idx_o,
  output logic                          any_o
);

  localparam int unsigned LW = $clog2(NUM_LEVELS);

  always_comb begin
    idx_o = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ne_i[i]) begin
        idx_o = LW'(i);
      end
    end
    any_o = |ne_i;
  end

endmodule

// ===== sv/spmq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// spmq_entry_ram
// Entry storage, one row per level; one write port, one registered read.
// ----------------------------------------------------------------------------
module spmq_entry_ram import spmq_pkg::*; #(
  parameter int unsigned NUM_LEVELS  = 16,
  parameter int unsigned LEVEL_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(NUM_LEVELS)-1:0]  wlvl_i,
  input  logic [$clog2(LEVEL_DEPTH)-1:0] wptr_i,
  input  logic [15:0]                    wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(NUM_LEVELS)-1:0]  rlvl_i,
  input  logic [$clog2(LEVEL_DEPTH)-1:0] rptr_i,
  output logic [15:0]                    rdata_o
);

  logic [15:0] mem [NUM_LEVELS][LEVEL_DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wlvl_i][wptr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[rlvl_i][rptr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/strict_priority_multilevel_queue_unit.sv =====
// ----------------------------------------------------------------------------
// strict_priority_multilevel_queue_unit
// Strict-priority queue of task ids, one FIFO per level, level 0 first.
// ----------------------------------------------------------------------------
// A request passes through the request register, then the response register.
// Throughput: one request per cycle unless the output stalls; the per-level
//   pointers, counts and non-empty flags update in one pass; the encoder picks the dequeue level.
// Reset: pointers, fill counts, non-empty flags and both stage valids clear
//   at once; entry storage is not cleared, so no sweep follows reset.
module strict_priority_multilevel_queue_unit import spmq_pkg::*; #(
  parameter int unsigned NUM_LEVELS  = 16,
  parameter int unsigned LEVEL_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_o
);

  localparam int unsigned LW = $clog2(NUM_LEVELS);
  localparam int unsigned PW = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Stage 1: request register
  logic s1_valid_q;
  req_t s1_q;

  // Per-level queue state
  logic [PW-1:0]         head_q [NUM_LEVELS];
  logic [PW-1:0]         head_d [NUM_LEVELS];
  logic [PW-1:0]         tail_q [NUM_LEVELS];
  logic [PW-1:0]         tail_d [NUM_LEVELS];
  logic [CW-1:0]         cnt_q  [NUM_LEVELS];
  logic [CW-1:0]         cnt_d  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] ne_q, ne_d;

  // Stage 2: response register (task id comes from the RAM read register)
  logic       s2_valid_q;
  status_e    st_q, st_d;
  logic [3:0] served_q, served_d;
  logic       ae_q, ae_d;
  logic [15:0] rdata;

  logic          advance, fire;
  logic [LW-1:0] lvl_idx, sel_idx;
  logic          any_ne, in_range, enq_ok, deq_ok;

  // Response register frees up when empty or being drained.
  assign advance    = !s2_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  spmq_prio_enc #(
    .NUM_LEVELS(NUM_LEVELS)
  ) u_prio_enc (
    .ne_i (ne_q),
    .idx_o(sel_idx),
    .any_o(any_ne)
  );

  assign lvl_idx  = LW'(s1_q.level);
  // Levels at or above NUM_LEVELS are dropped like a full level.
  assign in_range = 32'(s1_q.level) < NUM_LEVELS;
  assign enq_ok   = (s1_q.req_type == REQ_ENQ) && in_range &&
                    (cnt_q[lvl_idx] != CW'(LEVEL_DEPTH));
  assign deq_ok   = (s1_q.req_type == REQ_DEQ) && any_ne;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    ne_d   = ne_q;
    if (enq_ok) begin
      tail_d[lvl_idx] = next_ptr(tail_q[lvl_idx]);
      cnt_d[lvl_idx]  = cnt_q[lvl_idx] + 1'b1;
      ne_d[lvl_idx]   = 1'b1;
    end
    if (deq_ok) begin
      head_d[sel_idx] = next_ptr(head_q[sel_idx]);
      cnt_d[sel_idx]  = cnt_q[sel_idx] - 1'b1;
      if (cnt_q[sel_idx] == CW'(1)) begin
        ne_d[sel_idx] = 1'b0;
      end
    end
  end

  always_comb begin
    if (s1_q.req_type == REQ_ENQ) begin
      st_d = enq_ok ? ST_ENQ : ST_DROP;
    end else begin
      st_d = any_ne ? ST_DEQ : ST_EMPTY;
    end
    served_d = deq_ok ? 4'(sel_idx) : 4'd0;
    ae_d     = ~|ne_d;
  end

  spmq_entry_ram #(
    .NUM_LEVELS (NUM_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (fire && enq_ok),
    .wlvl_i (lvl_idx),
    .wptr_i (tail_q[lvl_idx]),
    .wdata_i(s1_q.task_id),
    .re_i   (fire && deq_ok),
    .rlvl_i (sel_idx),
    .rptr_i (head_q[sel_idx]),
    .rdata_o(rdata)
  );

  // Request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_i;
    end
  end

  // Queue state commits when the request moves to the response stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      ne_q <= '0;
    end else if (fire) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      ne_q   <= ne_d;
    end
  end

  // Response stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      st_q     <= st_d;
      served_q <= served_d;
      ae_q     <= ae_d;
    end
  end

  assign out_valid_o         = s2_valid_q;
  assign out_o.status        = st_q;
  assign out_o.out_task      = (st_q == ST_DEQ) ? rdata : 16'd0;
  assign out_o.served_level  = served_q;
  assign out_o.all_empty     = ae_q;

  // A successful enqueue always leaves at least one level occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == ST_ENQ) |-> !out_o.all_empty)
    else $error("enqueue reported all levels empty");

  // An empty dequeue leaves every level empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == ST_EMPTY) |-> out_o.all_empty)
    else $error("empty dequeue with occupied levels");

  // Non-empty flags track the fill counts, which stay within depth.
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (ne_q[g] == (cnt_q[g] != '0)) && (cnt_q[g] <= CW'(LEVEL_DEPTH)))
      else $error("level flag or fill count inconsistent");
  end

endmodule
